// ----- src/sha_bsh_pkg.sv -----
// Shared types, round constants and helper functions for the SHA-256 byte stream hasher.
// No dependencies; the schedule, core and top-level files import this package.
package sha_bsh_pkg;

	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned BLK_AW    = 4;
	localparam int unsigned CNT_W     = 61;
	localparam int unsigned HASH_WORDS = 8;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;
	typedef logic [HASH_WORDS-1:0][31:0] hash_t;

	// Control from the sequencer to the compression core.
	typedef struct packed {
		logic load;      // copy chain value into working variables
		logic round;     // run one round
		logic fold;      // add working variables into chain value
		logic reset_iv;  // return chain value to the initial hash
	} core_ctl_t;

	// Control from the sequencer to the message schedule.
	typedef struct packed {
		logic step;      // produce the next schedule word
		logic from_mem;  // take it from the block memory, not the recurrence
	} sched_ctl_t;

	localparam word_t H_INIT [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input logic [4:0] n);
		return (x >> n) | (x << (6'd32 - {1'b0, n}));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
	endfunction

	// Merge one byte into a big-endian block word; lane 0 starts a fresh word.
	function automatic word_t merge_byte(input word_t old, input logic [7:0] b,
			input logic [1:0] lane);
		word_t shifted;
		shifted = {24'd0, b} << {~lane, 3'b000};
		if (lane == 2'd0) begin
			return shifted;
		end
		return old | shifted;
	endfunction

endpackage

// ----- src/sha_bsh_if.sv -----
// Valid/ready channel interfaces for the byte input and the digest output.
// Depends on nothing.
interface sha_bsh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_message, output ready);
endinterface

interface sha_bsh_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

// ----- src/sha_bsh_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module sha_bsh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/sha_bsh_sched.sv -----
// Message schedule: sixteen-word history line that yields one schedule word per step.
// Depends on sha_bsh_pkg.
module sha_bsh_sched
	import sha_bsh_pkg::*;
(
	input  logic       clk,
	input  sched_ctl_t ctl,
	input  word_t      mem_word,
	output word_t      w
);

	word_t hist_q [BLK_WORDS];
	word_t w_q;
	word_t w_next;

	// hist_q[15] is the newest word, hist_q[0] the one sixteen steps back
	always_comb begin
		if (ctl.from_mem) begin
			w_next = mem_word;
		end else begin
			w_next = hist_q[0] + small_sig0(hist_q[1]) + hist_q[9] + small_sig1(hist_q[14]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[BLK_WORDS-1] <= w_next;
			w_q <= w_next;
		end
	end

	assign w = w_q;

endmodule

// ----- src/sha_bsh_core.sv -----
// Compression core: working variables, one round per cycle while ctl.round is set, and the chain value.
// Depends on sha_bsh_pkg.
module sha_bsh_core
	import sha_bsh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctl_t  ctl,
	input  logic [5:0] round_idx,
	input  word_t      w,
	output hash_t      chain
);

	word_t chain_q [HASH_WORDS];
	word_t v_q [HASH_WORDS];
	word_t t1;
	word_t t2;

	always_comb begin
		t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ K_TAB[round_idx] + w;
		t2 = big_sig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else if (ctl.reset_iv) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < HASH_WORDS; i++) begin
			chain[i] = chain_q[i];
		end
	end

endmodule

// ----- src/sha256_byte_stream_hasher.sv -----
// SHA-256 over a byte stream. A byte word is accepted, then read-merged-written into the
// 16-word block RAM; no new byte is taken until that write is done. A full block is then
// compressed: RAM load overlapped with the 64 rounds, one round per cycle, then a fold.
// End of message: pad, zero-fill (a long tail compresses and starts a fresh block), length,
// compression, hand-off; the 8 digest words then leave one per cycle while ready is high.
// Reset: chain value to the initial hash, byte count zero; block RAM is not cleared.
module sha256_byte_stream_hasher
	import sha_bsh_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	sha_bsh_byte_if.sink            byte_in,
	sha_bsh_digest_if.source        digest_out
);

	// Sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_BYTE   = 4'd1;
	localparam logic [3:0] ST_PAD_RD = 4'd2;
	localparam logic [3:0] ST_PAD_WR = 4'd3;
	localparam logic [3:0] ST_ZERO   = 4'd4;
	localparam logic [3:0] ST_LEN_HI = 4'd5;
	localparam logic [3:0] ST_LEN_LO = 4'd6;
	localparam logic [3:0] ST_COMP   = 4'd7;
	localparam logic [3:0] ST_EMIT   = 4'd8;

	// Where to go once a compression finishes
	localparam logic [1:0] AFT_BYTE  = 2'd0;
	localparam logic [1:0] AFT_LONG  = 2'd1;
	localparam logic [1:0] AFT_FINAL = 2'd2;

	// Compression timeline, in cycles of ST_COMP
	localparam logic [6:0] CYC_LOAD       = 7'd1;
	localparam logic [6:0] CYC_RND_FIRST  = 7'd2;
	localparam logic [6:0] CYC_RND_LAST   = 7'd65;
	localparam logic [6:0] CYC_MEM_LAST   = 7'd16;
	localparam logic [6:0] CYC_SCHED_LAST = 7'd64;
	localparam logic [6:0] CYC_FOLD       = 7'd66;

	localparam logic [BLK_AW-1:0] ADDR_LEN_HI = 4'd14;
	localparam logic [BLK_AW-1:0] ADDR_LEN_LO = 4'd15;

	logic [3:0]       state_q;
	logic [1:0]       after_q;
	logic [6:0]       cyc_q;
	logic [4:0]       zi_q;
	logic             long_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       byte_q;
	logic             eom_q;

	logic              ram_we;
	logic [BLK_AW-1:0] ram_waddr;
	word_t             ram_wdata;
	logic [BLK_AW-1:0] ram_raddr;
	word_t             ram_rdata;

	core_ctl_t  core_ctl;
	sched_ctl_t sched_ctl;
	logic [6:0] round_off;
	word_t      sched_w;
	hash_t      chain;
	logic [63:0] bit_len;

	word_t      obuf_q [HASH_WORDS];
	logic [2:0] oidx_q;
	logic       out_busy_q;
	logic       in_fire;
	logic       out_fire;
	logic       emit_go;

	assign in_fire  = byte_in.valid && byte_in.ready;
	assign out_fire = digest_out.valid && digest_out.ready;
	assign emit_go  = (state_q == ST_EMIT) && !out_busy_q;
	assign bit_len  = {byte_count_q, 3'b000};

	// Take one item at a time; the block RAM is only touched by the sequencer
	assign byte_in.ready = (state_q == ST_IDLE);

	sha_bsh_ram #(
		.WIDTH (32),
		.DEPTH (BLK_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = byte_count_q[5:2];
		ram_wdata = ram_rdata;
		ram_raddr = byte_count_q[5:2];
		case (state_q)
			ST_BYTE: begin
				ram_we    = 1'b1;
				ram_wdata = merge_byte(ram_rdata, byte_q, byte_count_q[1:0]);
			end
			ST_PAD_WR: begin
				ram_we    = 1'b1;
				ram_wdata = merge_byte(ram_rdata, PAD_BYTE, byte_count_q[1:0]);
			end
			ST_ZERO: begin
				ram_we    = !zi_q[4];
				ram_waddr = zi_q[3:0];
				ram_wdata = '0;
			end
			ST_LEN_HI: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_LEN_HI;
				ram_wdata = bit_len[63:32];
			end
			ST_LEN_LO: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_LEN_LO;
				ram_wdata = bit_len[31:0];
			end
			ST_COMP: begin
				ram_raddr = cyc_q[BLK_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// RAM read data feeds the schedule register, which feeds the rounds; each runs ahead of the next
	assign round_off = cyc_q - CYC_RND_FIRST;

	always_comb begin
		core_ctl.load     = (state_q == ST_COMP) && (cyc_q == CYC_LOAD);
		core_ctl.round    = (state_q == ST_COMP) && (cyc_q >= CYC_RND_FIRST)
			&& (cyc_q <= CYC_RND_LAST);
		core_ctl.fold     = (state_q == ST_COMP) && (cyc_q == CYC_FOLD);
		core_ctl.reset_iv = emit_go;
		sched_ctl.step     = (state_q == ST_COMP) && (cyc_q >= CYC_LOAD)
			&& (cyc_q <= CYC_SCHED_LAST);
		sched_ctl.from_mem = (cyc_q <= CYC_MEM_LAST);
	end

	sha_bsh_sched u_sched (
		.clk      (clk),
		.ctl      (sched_ctl),
		.mem_word (ram_rdata),
		.w        (sched_w)
	);

	sha_bsh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (core_ctl),
		.round_idx (round_off[5:0]),
		.w         (sched_w),
		.chain     (chain)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			after_q      <= AFT_BYTE;
			cyc_q        <= '0;
			zi_q         <= '0;
			long_q       <= 1'b0;
			byte_count_q <= '0;
			eom_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						eom_q <= byte_in.end_of_message;
						if (byte_in.has_byte) begin
							state_q <= ST_BYTE;
						end else if (byte_in.end_of_message) begin
							state_q <= ST_PAD_RD;
						end
					end
				end
				ST_BYTE: begin
					byte_count_q <= byte_count_q + CNT_W'(1);
					if (byte_count_q[5:0] == 6'h3f) begin
						// block full: compress before anything else
						state_q <= ST_COMP;
						after_q <= AFT_BYTE;
						cyc_q   <= '0;
					end else if (eom_q) begin
						state_q <= ST_PAD_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD_RD: begin
					state_q <= ST_PAD_WR;
				end
				ST_PAD_WR: begin
					zi_q    <= {1'b0, byte_count_q[5:2]} + 5'd1;
					long_q  <= (byte_count_q[5:3] == 3'd7);
					state_q <= ST_ZERO;
				end
				ST_ZERO: begin
					if (!zi_q[4]) begin
						zi_q <= zi_q + 5'd1;
					end else if (long_q) begin
						// no room for the length: compress, then a fresh zero block
						state_q <= ST_COMP;
						after_q <= AFT_LONG;
						cyc_q   <= '0;
					end else begin
						state_q <= ST_LEN_HI;
					end
				end
				ST_LEN_HI: begin
					state_q <= ST_LEN_LO;
				end
				ST_LEN_LO: begin
					state_q <= ST_COMP;
					after_q <= AFT_FINAL;
					cyc_q   <= '0;
				end
				ST_COMP: begin
					cyc_q <= cyc_q + 7'd1;
					if (cyc_q == CYC_FOLD) begin
						case (after_q)
							AFT_BYTE: begin
								state_q <= eom_q ? ST_PAD_RD : ST_IDLE;
							end
							AFT_LONG: begin
								zi_q    <= '0;
								long_q  <= 1'b0;
								state_q <= ST_ZERO;
							end
							AFT_FINAL: begin
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_EMIT: begin
					// hold until the previous digest has drained
					if (!out_busy_q) begin
						byte_count_q <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_q <= byte_in.data_byte;
		end
	end

	// Digest buffer: load all eight words, shift one out per handshake
	always_ff @(posedge clk) begin
		if (emit_go) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				obuf_q[i] <= chain[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < HASH_WORDS - 1; i++) begin
				obuf_q[i] <= obuf_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			oidx_q     <= '0;
		end else if (emit_go) begin
			out_busy_q <= 1'b1;
			oidx_q     <= '0;
		end else if (out_fire) begin
			oidx_q <= oidx_q + 3'd1;
			if (oidx_q == 3'd7) begin
				out_busy_q <= 1'b0;
			end
		end
	end

	assign digest_out.valid       = out_busy_q;
	assign digest_out.digest_word = obuf_q[0];
	assign digest_out.word_index  = oidx_q;
	assign digest_out.last_word   = (oidx_q == 3'd7);

	// The compression counter never runs past the fold cycle
	a_comp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (cyc_q <= CYC_FOLD))
		else $error("compression counter overran");

	// A byte that fills the block always starts a compression
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BYTE && byte_count_q[5:0] == 6'h3f) |=> (state_q == ST_COMP))
		else $error("full block not compressed");

	// Handing off a digest fills the buffer and restarts the message
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (out_busy_q && oidx_q == 3'd0 && state_q == ST_IDLE
			&& byte_count_q == '0))
		else $error("digest hand-off incomplete");

	// After the last digest word leaves, the output goes quiet
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && digest_out.last_word) |=> !digest_out.valid)
		else $error("digest output kept running after last word");

endmodule
